// ===== sv/cfml_pkg.sv =====
package cfml_pkg;

   localparam int GAIN_FRACTION_BITS_DEF = 24;

   localparam int SAMPLE_W    = 16;
   localparam int FADE_W      = 7;
   localparam int COEF_W      = 6;
   localparam int PEAK_W      = 15;
   localparam int STEP_W      = 16;
   localparam int MAG_W       = 17;
   localparam int SCALED_W    = 21;
   localparam int DIV50_W     = 22;
   localparam int DIV50_SHIFT = 27;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CROSSFADE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_STEP = 2'd2;

   localparam logic [FADE_W-1:0] FADE_RESET  = 7'd50;
   localparam logic [FADE_W-1:0] FADE_CENTER = 7'd50;
   localparam logic [FADE_W-1:0] FADE_FULL   = 7'd100;
   localparam logic [PEAK_W-1:0] PEAK_RESET  = 15'd30000;
   localparam logic [STEP_W-1:0] STEP_RESET  = 16'd17;

   // ceil(2^27 / 50): exact floor division for dividends below 2^21
   localparam logic [DIV50_W-1:0] DIV50_MULT = 22'd2684355;

   typedef struct packed {
      logic load;
      logic scale_mul;
      logic scale_div;
      logic sum;
      logic mul_lo;
      logic mul_hi;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic over_limit;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/cfml_if.sv =====
interface cfml_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_a;
   logic signed [15:0] sample_b;

   modport source(output valid, output sample_a, output sample_b, input ready);
   modport sink(input valid, input sample_a, input sample_b, output ready);
endinterface

interface cfml_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] mixed_sample;
   logic               limiting;

   modport source(output valid, output mixed_sample, output limiting, input ready);
   modport sink(input valid, input mixed_sample, input limiting, output ready);
endinterface

// ===== sv/cfml_ctrl.sv =====
module cfml_ctrl #(
   parameter int GAIN_FRACTION_BITS = cfml_pkg::GAIN_FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cfml_pkg::stat_type stat,
   output cfml_pkg::cmd_type  cmd
);
   import cfml_pkg::*;

   localparam int CW = $clog2(GAIN_FRACTION_BITS + 1);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SCALE_MUL = 4'd1;
   localparam logic [3:0] ST_SCALE_DIV = 4'd2;
   localparam logic [3:0] ST_SUM       = 4'd3;
   localparam logic [3:0] ST_MUL_LO    = 4'd4;
   localparam logic [3:0] ST_MUL_HI    = 4'd5;
   localparam logic [3:0] ST_CHECK     = 4'd6;
   localparam logic [3:0] ST_DIV       = 4'd7;
   localparam logic [3:0] ST_REMUL_LO  = 4'd8;
   localparam logic [3:0] ST_REMUL_HI  = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCALE_MUL;
            end
         end
         ST_SCALE_MUL: begin
            cmd.scale_mul = 1'b1;
            state_in      = ST_SCALE_DIV;
         end
         ST_SCALE_DIV: begin
            cmd.scale_div = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.over_limit) begin
               cmd.div_init = 1'b1;
               cnt_in       = CW'(GAIN_FRACTION_BITS - 1);
               state_in     = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_REMUL_LO;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_REMUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_REMUL_HI;
         end
         ST_REMUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== sv/cfml_dp.sv =====
module cfml_dp #(
   parameter int GAIN_FRACTION_BITS = cfml_pkg::GAIN_FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [cfml_pkg::SAMPLE_W-1:0] sample_a,
   input  logic signed [cfml_pkg::SAMPLE_W-1:0] sample_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cfml_pkg::SAMPLE_W-1:0] mixed_sample,
   output logic                                 limiting,
   input  logic                                 csr_we,
   input  logic [cfml_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cfml_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  cfml_pkg::cmd_type                    cmd,
   output cfml_pkg::stat_type                   stat
);
   import cfml_pkg::*;

   localparam int F   = GAIN_FRACTION_BITS;
   localparam int GW  = F + 1;
   localparam int GHW = GW - 16;
   localparam int PW  = F + MAG_W + 1;
   localparam logic [GW:0] GAIN_ONE_X = (GW + 1)'(1) << F;

   // configuration
   logic [FADE_W-1:0] fade_ff;
   logic [PEAK_W-1:0] peak_ff;
   logic [STEP_W-1:0] step_ff;

   // limiter state and working registers
   logic [GW-1:0]               gain_ff;
   logic [GW-1:0]               gwork_ff;
   logic signed [SAMPLE_W-1:0]  a_ff, b_ff;
   logic                        scale_b_ff;
   logic [COEF_W-1:0]           coef_ff;
   logic [SCALED_W-1:0]         sp_ff;
   logic                        sp_neg_ff;
   logic [SCALED_W+DIV50_W-1:0] qm_ff;
   logic [MAG_W-1:0]            mag_ff;
   logic                        sum_neg_ff;
   logic [PW-1:0]               prod_ff;
   logic [MAG_W-1:0]            rem_ff;
   logic                        cut_ff;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  mixed_ff;
   logic                        limiting_ff;

   logic [GW:0]                 gain_sum;
   logic [FADE_W-1:0]           pos;
   logic signed [SAMPLE_W-1:0]  sel_x;
   logic signed [MAG_W-1:0]     sel_x_ext;
   logic [MAG_W-1:0]            abs_x;
   logic [MAG_W-1:0]            qv;
   logic signed [MAG_W-1:0]     scaled;
   logic signed [MAG_W-1:0]     other;
   logic signed [MAG_W-1:0]     sum;
   logic [MAG_W+15:0]           pp_lo;
   logic [MAG_W+GHW-1:0]        pp_hi;
   logic [PW-1:0]               lim;
   logic [MAG_W:0]              rem_sh;
   logic                        rem_ge;
   logic [SAMPLE_W-1:0]         res_mag;

   always_comb begin
      gain_sum  = {1'b0, gain_ff} + (GW + 1)'(step_ff);
      pos       = (fade_ff > FADE_FULL) ? FADE_FULL : fade_ff;
      sel_x     = scale_b_ff ? b_ff : a_ff;
      sel_x_ext = MAG_W'(sel_x);
      abs_x     = sel_x[SAMPLE_W-1] ? MAG_W'(-sel_x_ext) : MAG_W'(sel_x_ext);
      qv        = {1'b0, qm_ff[DIV50_SHIFT +: SAMPLE_W]};
      scaled    = sp_neg_ff ? -$signed(qv) : $signed(qv);
      other     = scale_b_ff ? MAG_W'(a_ff) : MAG_W'(b_ff);
      sum       = other + scaled;
      pp_lo     = mag_ff * gwork_ff[15:0];
      pp_hi     = mag_ff * gwork_ff[GW-1:16];
      lim       = PW'({peak_ff, {F{1'b0}}});
      rem_sh    = {rem_ff, 1'b0};
      rem_ge    = (rem_sh >= {1'b0, mag_ff});
      res_mag   = prod_ff[F +: SAMPLE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff <= FADE_RESET;
         peak_ff <= PEAK_RESET;
         step_ff <= STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CROSSFADE:     fade_ff <= csr_wdata[FADE_W-1:0];
            CSR_PEAK_LIMIT:    peak_ff <= csr_wdata[PEAK_W-1:0];
            CSR_RECOVERY_STEP: step_ff <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_ONE_X[GW-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            gain_ff      <= gwork_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff       <= sample_a;
         b_ff       <= sample_b;
         scale_b_ff <= (pos <= FADE_CENTER);
         coef_ff    <= (pos <= FADE_CENTER) ? COEF_W'(pos) : COEF_W'(FADE_FULL - pos);
         gwork_ff   <= (gain_sum > GAIN_ONE_X) ? GAIN_ONE_X[GW-1:0] : gain_sum[GW-1:0];
         cut_ff     <= 1'b0;
      end
      if (cmd.scale_mul) begin
         sp_ff     <= SCALED_W'(abs_x) * SCALED_W'(coef_ff);
         sp_neg_ff <= sel_x[SAMPLE_W-1];
      end
      if (cmd.scale_div) begin
         qm_ff <= sp_ff * DIV50_MULT;
      end
      if (cmd.sum) begin
         mag_ff     <= sum[MAG_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
         sum_neg_ff <= sum[MAG_W-1];
      end
      if (cmd.mul_lo) begin
         prod_ff <= PW'(pp_lo);
      end
      if (cmd.mul_hi) begin
         prod_ff <= prod_ff + (PW'(pp_hi) << 16);
      end
      // peak_limit < |sum| whenever the cut fires, so the quotient fits in F bits
      if (cmd.div_init) begin
         rem_ff   <= MAG_W'(peak_ff);
         gwork_ff <= '0;
         cut_ff   <= 1'b1;
      end
      if (cmd.div_step) begin
         rem_ff   <= rem_ge ? MAG_W'(rem_sh - {1'b0, mag_ff}) : rem_sh[MAG_W-1:0];
         gwork_ff <= {gwork_ff[GW-2:0], rem_ge};
      end
      if (cmd.finish) begin
         mixed_ff    <= sum_neg_ff ? -$signed(res_mag) : $signed(res_mag);
         limiting_ff <= cut_ff;
      end
   end

   assign stat.over_limit = (prod_ff > lim);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign mixed_sample    = mixed_ff;
   assign limiting        = limiting_ff;

endmodule

// ===== sv/crossfade_mixer_with_limiter.sv =====
// Two-deck crossfader with a peak limiter. Each transfer on req carries one sample from
// deck A and one from deck B; each produces exactly one transfer on rsp with the mixed,
// limited sample and a flag that is set when the limiter gain was cut for that sample.
// The crossfader scales deck B by position/50 up to the center and deck A by
// (100-position)/50 past it. The shared Q1.F gain recovers by recovery_step per sample
// up to 1.0 and is cut to floor(peak_limit*2^F/|sum|) when the gain-scaled sum would
// pass peak_limit. Items are handled one at a time; when the gain is cut, a restoring
// divider that yields one quotient bit per cycle computes the new gain. The 17-bit
// |sum| by (F+1)-bit gain multiply is split at gain bit 16 into two partial products
// formed one after the other. A finished result waits in an output register, so the
// next item is taken while it is still unread. The user must write configuration
// (crossfade, peak_limit, recovery_step at indexes 0, 1, 2) only while the block is
// idle (not enforced by the block); writes to other indexes are ignored.
module crossfade_mixer_with_limiter #(
   parameter int GAIN_FRACTION_BITS = cfml_pkg::GAIN_FRACTION_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   cfml_req_if.sink                        req,
   cfml_rsp_if.source                      rsp,
   input logic                             csr_we,
   input logic [cfml_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [cfml_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cfml_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cfml_ctrl #(
      .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfml_dp #(
      .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .sample_a     (req.sample_a),
      .sample_b     (req.sample_b),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .mixed_sample (rsp.mixed_sample),
      .limiting     (rsp.limiting),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule

// ===== sv/cfml_checker.sv =====
module cfml_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] mixed_sample,
   input logic               limiting
);

   logic       req_xfer, rsp_xfer;
   logic [1:0] pending_ff, pending_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mixed_sample) && $stable(limiting))
      else $error("result changed while stalled");

   // output magnitude never exceeds the largest peak limit
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> mixed_sample != 16'sh8000)
      else $error("output reached negative full scale");

   // every result belongs to an accepted item
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted item");

   // one item at work and one result waiting at most
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many items outstanding");

endmodule

bind crossfade_mixer_with_limiter cfml_checker u_cfml_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .mixed_sample (rsp.mixed_sample),
   .limiting     (rsp.limiting)
);

// ===== test/crossfade_mixer_with_limiter_test.sv =====
module crossfade_mixer_with_limiter_test;
   import cfml_pkg::*;

   localparam int GAIN_F = GAIN_FRACTION_BITS_DEF;
   localparam longint unsigned GAIN_ONE = 64'd1 << GAIN_F;
   localparam int FADE_SPAN = 100;
   localparam int FADE_HALF = 50;
   localparam int RANDOM_ITEMS = 1750;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] EDGE_VALUES [0:4] =
      '{16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};

   typedef enum int {STYLE_RANDOM, STYLE_EDGE, STYLE_QUIET, STYLE_SILENT, STYLE_LOUD}
      sample_style_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] a;
      logic signed [SAMPLE_W-1:0] b;
   } deck_pair_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed;
      logic                       limiting;
   } mix_out_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cfml_req_if req_ch();
   cfml_rsp_if rsp_ch();

   crossfade_mixer_with_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and register copies
   logic [FADE_W-1:0] fade_pos;
   logic [PEAK_W-1:0] peak_lim;
   logic [STEP_W-1:0] recover_step;
   longint unsigned   gain_q;

   deck_pair_type deck_pairs[$];
   mix_out_type   pending_mixes[$];
   int            mismatches = 0;
   bit            req_taken = 1'b0;

   int gap_left = 0;
   int burst_left = 0;
   int stall_period = 1;
   int stall_duty = 1;
   int stall_phase = 0;
   int stall_left = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic mix_out_type mix_and_limit(input logic signed [SAMPLE_W-1:0] a,
                                                 input logic signed [SAMPLE_W-1:0] b);
      longint          sa;
      longint          sb;
      longint          total;
      longint          res;
      int              pos;
      longint unsigned g;
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned lim;
      bit              cut;
      mix_out_type     r;
      sa = a;
      sb = b;
      pos = (fade_pos > FADE_SPAN) ? FADE_SPAN : fade_pos;
      g = gain_q + recover_step;
      if (g > GAIN_ONE) g = GAIN_ONE;
      if (pos <= FADE_HALF) sb = (sb * pos) / FADE_HALF;
      else sa = (sa * (FADE_SPAN - pos)) / FADE_HALF;
      total = sa + sb;
      mag = (total < 0) ? -total : total;
      lim = peak_lim;
      lim = lim << GAIN_F;
      prod = mag * g;
      cut = prod > lim;
      if (cut) begin
         g = lim / mag;
         prod = mag * g;
      end
      gain_q = g;
      res = longint'(prod >> GAIN_F);
      if (total < 0) res = -res;
      r.mixed = res[SAMPLE_W-1:0];
      r.limiting = cut;
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_style_type style,
                                                              input bit neg);
      int mag;
      case (style)
         STYLE_EDGE:   return EDGE_VALUES[$urandom_range(0, 4)];
         STYLE_QUIET:  return 16'($urandom_range(0, 1023) - 512);
         STYLE_SILENT: return '0;
         STYLE_LOUD: begin
            mag = $urandom_range(20000, 32767);
            return 16'(neg ? -mag : mag);
         end
         default:      return 16'($urandom);
      endcase
   endfunction

   task automatic report_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_CROSSFADE:     fade_pos = data[FADE_W-1:0];
         CSR_PEAK_LIMIT:    peak_lim = data[PEAK_W-1:0];
         CSR_RECOVERY_STEP: recover_step = data[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_pair(input logic signed [SAMPLE_W-1:0] a,
                           input logic signed [SAMPLE_W-1:0] b);
      deck_pair_type p;
      p.a = a;
      p.b = b;
      deck_pairs.push_back(p);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (deck_pairs.size() != 0 || pending_mixes.size() != 0);
   endtask

   // sender: bursts with random gaps, hold an offered item until its transfer
   always @(negedge clock) begin
      if (!req_ch.valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (deck_pairs.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.sample_a <= deck_pairs[0].a;
            req_ch.sample_b <= deck_pairs[0].b;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: periodic stall pattern, re-picked after a random run
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_period = $urandom_range(1, 16);
         stall_duty = ($urandom_range(0, 3) == 0) ? stall_period
                                                 : $urandom_range(1, stall_period);
         stall_left = $urandom_range(40, 400);
         stall_phase = 0;
      end
      stall_left--;
      rsp_ch.ready <= (stall_phase < stall_duty);
      stall_phase = (stall_phase + 1) % stall_period;
   end

   always @(posedge clock) begin
      mix_out_type want;
      if (!reset) begin
         // check results before predicting so a same-edge transfer cannot be matched
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_mixes.size() == 0) begin
               report_failure($sformatf("unexpected result: mixed_sample %0d limiting %0b",
                                        rsp_ch.mixed_sample, rsp_ch.limiting));
            end else begin
               want = pending_mixes.pop_front();
               if (rsp_ch.mixed_sample !== want.mixed || rsp_ch.limiting !== want.limiting)
                  report_failure($sformatf(
                     "mismatch: mixed_sample exp %0d got %0d, limiting exp %0b got %0b",
                     want.mixed, rsp_ch.mixed_sample, want.limiting, rsp_ch.limiting));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_mixes.push_back(mix_and_limit(req_ch.sample_a, req_ch.sample_b));
            void'(deck_pairs.pop_front());
            req_taken = 1'b1;
         end
      end
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int               issued;
      int               count;
      int               k;
      bit               loud_phase;
      bit               neg;
      sample_style_type style;
      logic [CSR_DATA_W-1:0] data;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.sample_a = '0;
      req_ch.sample_b = '0;
      rsp_ch.ready = 1'b0;
      fade_pos = FADE_RESET;
      peak_lim = PEAK_RESET;
      recover_step = STEP_RESET;
      gain_q = GAIN_ONE;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: centered fader, both decks at full volume
      add_pair(16'sh0000, 16'sh0000);
      add_pair(16'sh7FFF, 16'sh7FFF);
      add_pair(16'sh8000, 16'sh8000);
      add_pair(16'sh7FFF, 16'sh8000);
      add_pair(16'sh8000, 16'sh0000);
      add_pair(16'sh0001, 16'shFFFF);
      add_pair(16'sd100, 16'sd200);
      wait_idle();

      // deck B silenced, smallest nonzero limit, no recovery
      set_register(CSR_CROSSFADE, 16'd0);
      set_register(CSR_PEAK_LIMIT, 16'd1);
      set_register(CSR_RECOVERY_STEP, 16'd0);
      add_pair(16'sh7FFF, 16'sh8000);
      add_pair(16'sh8000, 16'sh7FFF);
      add_pair(16'sd3, 16'sd0);
      add_pair(16'shFFFF, 16'sd1);
      wait_idle();

      // deck A silenced, widest limit, fastest recovery
      set_register(CSR_CROSSFADE, 16'd100);
      set_register(CSR_PEAK_LIMIT, 16'd32767);
      set_register(CSR_RECOVERY_STEP, 16'd65535);
      add_pair(16'sh7FFF, 16'sh7FFF);
      add_pair(16'sh8000, 16'sh8000);
      add_pair(16'shFFFF, 16'shFFFF);
      add_pair(16'sd12345, -16'sd54);
      wait_idle();

      // fader past the end, zero limit, write to an unmapped index
      set_register(CSR_CROSSFADE, 16'd127);
      set_register(CSR_PEAK_LIMIT, 16'd0);
      set_register(CSR_UNUSED, 16'hFFFF);
      add_pair(16'sh7FFF, 16'sd5);
      add_pair(16'sh0000, 16'sh0000);
      add_pair(16'sh8000, 16'sh8000);
      wait_idle();

      // just off center on both sides
      set_register(CSR_CROSSFADE, 16'd51);
      set_register(CSR_PEAK_LIMIT, 16'd30000);
      set_register(CSR_RECOVERY_STEP, 16'd17);
      add_pair(16'sh8000, 16'sh7FFF);
      add_pair(16'sh7FFF, 16'sh7FFF);
      wait_idle();
      set_register(CSR_CROSSFADE, 16'd49);
      add_pair(16'sh7FFF, 16'sh8000);
      add_pair(-16'sd32767, 16'sh8000);
      wait_idle();

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, 9);
            data = (k == 0) ? 16'd0 : (k == 1) ? 16'd100 : (k == 2) ? 16'd50 :
                   (k == 3) ? 16'($urandom_range(101, 127)) : 16'($urandom_range(0, 100));
            if ($urandom_range(0, 3) == 0)
               data[CSR_DATA_W-1:FADE_W] = (CSR_DATA_W - FADE_W)'($urandom);
            set_register(CSR_CROSSFADE, data);
         end
         if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, 11);
            data = (k == 0) ? 16'd0 : (k == 1) ? 16'd32767 : (k == 2) ? 16'd1 :
                   (k == 3) ? 16'($urandom_range(1, 600)) : 16'($urandom_range(1, 32767));
            if ($urandom_range(0, 3) == 0) data[CSR_DATA_W-1] = 1'b1;
            set_register(CSR_PEAK_LIMIT, data);
         end
         if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, 7);
            data = (k == 0) ? 16'd0 : (k == 1) ? 16'd65535 :
                   (k == 2) ? 16'($urandom_range(0, 64)) : (k == 3) ? 16'd17 :
                   16'($urandom);
            set_register(CSR_RECOVERY_STEP, data);
         end
         if ($urandom_range(0, 7) == 0) set_register(CSR_UNUSED, 16'($urandom));

         // loud phases keep the limiter cutting, and the other batches give the gain time to recover
         loud_phase = ($urandom_range(0, 2) == 0);
         count = $urandom_range(50, 200);
         for (int i = 0; i < count; i++) begin
            style = sample_style_type'($urandom_range(0, 4));
            if (loud_phase && $urandom_range(0, 1) == 0) style = STYLE_LOUD;
            neg = 1'($urandom_range(0, 1));
            add_pair(pick_sample(style, neg), pick_sample(style, neg));
         end
         issued += count;
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_mixes.size() != 0)
         report_failure($sformatf("%0d results never arrived", pending_mixes.size()));
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/cfml_pkg.sv
sv/cfml_if.sv
sv/cfml_ctrl.sv
sv/cfml_dp.sv
sv/crossfade_mixer_with_limiter.sv
sv/cfml_checker.sv
test/crossfade_mixer_with_limiter_test.sv
